// ===== rtl/srtm_pkg.sv =====
// ---------------------------------------------------------------------------
// srtm_pkg: shared types and constants for the stripe transfer rate monitor
// Row layout of the stripe table, sequencer states and status codes.
// ---------------------------------------------------------------------------
package srtm_pkg;

    localparam int MAX_STRIPES = 256;
    localparam int IDX_W       = $clog2(MAX_STRIPES);
    localparam int CNT_W       = $clog2(MAX_STRIPES + 1);

    localparam int IN_W  = 112;
    localparam int OUT_W = 208;

    typedef struct packed {
        logic [31:0]        t_begin;
        logic [31:0]        t_latest;
        logic [47:0]        bytes;
        logic signed [48:0] avg_rate;
        logic signed [48:0] inst_rate;
    } row_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_COUNT = 2'd1,
        STAT_INDEX = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_CALC,
        S_AVG_GO,
        S_AVG_WAIT,
        S_INST_GO,
        S_INST_WAIT,
        S_WRITE,
        S_SUM,
        S_DONE
    } state_t;

endpackage

// ===== rtl/srtm_div.sv =====
// ---------------------------------------------------------------------------
// srtm_div: shared signed divider
// Restoring radix-2 division, one quotient bit per cycle.
// Quotient truncates toward zero.
// ---------------------------------------------------------------------------
module srtm_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [48:0] dividend,
    input  logic signed [32:0] divisor,
    output logic               done,
    output logic signed [48:0] quotient
);
    import srtm_pkg::*;

    logic [32:0] rem_reg,  rem_next;
    logic [47:0] dvd_reg,  dvd_next;
    logic [31:0] dvs_reg,  dvs_next;
    logic [5:0]  cnt_reg,  cnt_next;
    logic        neg_reg,  neg_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    logic [48:0] dvd_mag;
    logic [32:0] dvs_mag;
    logic [32:0] rem_sh;
    logic [33:0] diff;

    assign dvd_mag = dividend[48] ? 49'(-dividend) : 49'(dividend);
    assign dvs_mag = divisor[32] ? 33'(-divisor) : 33'(divisor);
    assign rem_sh  = {rem_reg[31:0], dvd_reg[47]};
    assign diff    = {1'b0, rem_sh} - {2'b00, dvs_reg};

    // load operands on start, then shift and subtract once a cycle
    always_comb
    begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            dvd_next  = dvd_mag[47:0];
            dvs_next  = dvs_mag[31:0];
            cnt_next  = '0;
            neg_next  = dividend[48] ^ divisor[32];
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[33])
            begin
                rem_next = diff[32:0];
                dvd_next = {dvd_reg[46:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                dvd_next = {dvd_reg[46:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd47)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    // apply sign to the magnitude quotient
    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed({1'b0, dvd_reg}) : $signed({1'b0, dvd_reg});

endmodule

// ===== rtl/srtm_table.sv =====
// ---------------------------------------------------------------------------
// srtm_table: stripe table memory
// One row per stripe, one write and one registered read per cycle.
// A valid bit per row makes cleared rows read as zero.
// ---------------------------------------------------------------------------
module srtm_table (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        clr_en,
    input  logic [srtm_pkg::CNT_W-1:0]  clr_lo,
    input  logic [srtm_pkg::CNT_W-1:0]  clr_hi,
    input  logic [srtm_pkg::IDX_W-1:0]  rd_addr,
    output srtm_pkg::row_t              rd_row,
    input  logic                        wr_en,
    input  logic [srtm_pkg::IDX_W-1:0]  wr_addr,
    input  srtm_pkg::row_t              wr_row
);
    import srtm_pkg::*;

    row_t                   mem [MAX_STRIPES];
    row_t                   rd_data_reg;
    logic                   rd_valid_reg;
    logic [MAX_STRIPES-1:0] valid_reg, valid_next;

    // drop rows in the cleared range, mark written rows
    always_comb
    begin
        valid_next = valid_reg;
        for (int i = 0; i < MAX_STRIPES; i++)
        begin
            if (clr_en && (CNT_W'(i) >= clr_lo) && (CNT_W'(i) < clr_hi))
            begin
                valid_next[i] = 1'b0;
            end
        end
        if (wr_en)
        begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_row;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_row = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ===== rtl/stripe_transfer_rate_monitor.sv =====
// ---------------------------------------------------------------------------
// stripe_transfer_rate_monitor: per-stripe progress and rate tracking
// Usage: each request on the s_ side is a progress report for one stripe
// (index, stripe count, timestamp, cumulative bytes). The block updates the
// stripe table and returns one result on the m_ side with a status, the
// overall elapsed time and the sums of average rate, instant rate and bytes
// over the active stripes.
// Flow: a report steps through the table read, the difference step, up to two
// passes of the shared divider (average, then instant rate) and the table
// write, then walks the active rows (one row a cycle through its single read port).
// Rejected reports skip the divisions. s_tready is high only while the
// sequencer is idle, so one report is in work at a time; a new report is
// taken only once the last one's result has gone to the output register.
// The result sits in an output register; while the receiver stalls the
// block still takes the next report and holds its result until the
// register frees. Reset clears the stripe valid bits, the counters and the
// overall times at once; no clearing pass is needed.
// ---------------------------------------------------------------------------
module stripe_transfer_rate_monitor (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // stripe_index[15:0], stripe_count[31:16], timestamp[63:32], bytes_done[111:64]
    input  logic [srtm_pkg::IN_W-1:0]    s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // status[1:0], overall_elapsed[34:2], sum_average_rate[91:35],
    // sum_instant_rate[148:92], total_bytes[204:149], zero pad[207:205]
    output logic [srtm_pkg::OUT_W-1:0]   m_tdata
);
    import srtm_pkg::*;

    state_t state_reg, state_next;

    logic signed [15:0] idx_in;
    logic [15:0]        cnt_in;
    logic [31:0]        ts_in;
    logic [47:0]        bytes_in;

    logic [IDX_W-1:0]   idx_reg,    idx_next;
    logic [31:0]        ts_reg,     ts_next;
    logic [47:0]        bytes_reg,  bytes_next;
    status_t            status_reg, status_next;
    logic [CNT_W-1:0]   active_reg, active_next;
    logic [31:0]        ob_reg,     ob_next;
    logic [31:0]        ol_reg,     ol_next;
    row_t               work_reg,   work_next;
    logic signed [32:0] abs_el_reg, abs_el_next;
    logic signed [32:0] del_reg,    del_next;
    logic signed [48:0] dsz_reg,    dsz_next;
    logic [CNT_W-1:0]   walk_reg,   walk_next;
    logic               pend_reg,   pend_next;
    logic [56:0]        acc_avg_reg,  acc_avg_next;
    logic [56:0]        acc_inst_reg, acc_inst_next;
    logic [55:0]        acc_b_reg,    acc_b_next;
    logic               ovalid_reg, ovalid_next;
    logic [OUT_W-1:0]   odata_reg,  odata_next;

    logic               accept;
    logic               count_bad;
    logic               index_bad;
    logic               walk_issue;
    logic               out_free;
    logic [31:0]        begin_new;
    logic signed [32:0] elapsed;

    logic               clr_en;
    logic [IDX_W-1:0]   rd_addr;
    row_t               rd_row;
    logic               wr_en;

    logic               div_start;
    logic signed [48:0] div_dividend;
    logic signed [32:0] div_divisor;
    logic               div_done;
    logic signed [48:0] div_quot;

    assign idx_in   = $signed(s_tdata[15:0]);
    assign cnt_in   = s_tdata[31:16];
    assign ts_in    = s_tdata[63:32];
    assign bytes_in = s_tdata[111:64];

    assign s_tready   = (state_reg == S_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign count_bad  = (cnt_in > 16'(MAX_STRIPES));
    assign index_bad  = idx_in[15] || ($unsigned(idx_in) >= cnt_in);
    assign walk_issue = (walk_reg < active_reg);
    assign out_free   = !ovalid_reg || m_tready;
    assign begin_new  = (rd_row.t_begin == 32'd0) ? ts_reg : rd_row.t_begin;
    assign elapsed    = $signed({1'b0, ol_reg}) - $signed({1'b0, ob_reg});

    assign clr_en  = accept && !count_bad && (cnt_in[CNT_W-1:0] > active_reg);
    assign rd_addr = (state_reg == S_SUM) ? walk_reg[IDX_W-1:0] : idx_reg;
    assign wr_en   = (state_reg == S_WRITE);

    srtm_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .clr_en  (clr_en),
        .clr_lo  (active_reg),
        .clr_hi  (cnt_in[CNT_W-1:0]),
        .rd_addr (rd_addr),
        .rd_row  (rd_row),
        .wr_en   (wr_en),
        .wr_addr (idx_reg),
        .wr_row  (work_reg)
    );

    // feed the divider with the average or the instant operands
    assign div_start    = ((state_reg == S_AVG_GO) && (abs_el_reg != 33'sd0)) ||
                          ((state_reg == S_INST_GO) && (del_reg != 33'sd0));
    assign div_dividend = (state_reg == S_AVG_GO) ? $signed({1'b0, bytes_reg}) : dsz_reg;
    assign div_divisor  = (state_reg == S_AVG_GO) ? abs_el_reg : del_reg;

    srtm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (count_bad || index_bad) ? S_SUM : S_READ;
                end
            end
            S_READ:      state_next = S_CALC;
            S_CALC:      state_next = S_AVG_GO;
            S_AVG_GO:    state_next = div_start ? S_AVG_WAIT : S_INST_GO;
            S_AVG_WAIT:  state_next = div_done ? S_INST_GO : S_AVG_WAIT;
            S_INST_GO:   state_next = div_start ? S_INST_WAIT : S_WRITE;
            S_INST_WAIT: state_next = div_done ? S_WRITE : S_INST_WAIT;
            S_WRITE:     state_next = S_SUM;
            S_SUM:       state_next = (!walk_issue && !pend_reg) ? S_DONE : S_SUM;
            S_DONE:      state_next = out_free ? S_IDLE : S_DONE;
            default:     state_next = S_IDLE;
        endcase
    end

    // datapath updates per state
    always_comb
    begin
        idx_next      = idx_reg;
        ts_next       = ts_reg;
        bytes_next    = bytes_reg;
        status_next   = status_reg;
        active_next   = active_reg;
        ob_next       = ob_reg;
        ol_next       = ol_reg;
        work_next     = work_reg;
        abs_el_next   = abs_el_reg;
        del_next      = del_reg;
        dsz_next      = dsz_reg;
        walk_next     = walk_reg;
        pend_next     = 1'b0;
        acc_avg_next  = acc_avg_reg;
        acc_inst_next = acc_inst_reg;
        acc_b_next    = acc_b_reg;
        ovalid_next   = ovalid_reg && !m_tready;
        odata_next    = odata_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    idx_next      = idx_in[IDX_W-1:0];
                    ts_next       = ts_in;
                    bytes_next    = bytes_in;
                    walk_next     = '0;
                    acc_avg_next  = '0;
                    acc_inst_next = '0;
                    acc_b_next    = '0;
                    if (count_bad)
                    begin
                        status_next = STAT_COUNT;
                    end
                    else
                    begin
                        active_next = cnt_in[CNT_W-1:0];
                        status_next = index_bad ? STAT_INDEX : STAT_OK;
                    end
                end
            end
            S_CALC:
            begin
                // stamp the first report, take the differences
                work_next.t_begin   = begin_new;
                work_next.t_latest  = ts_reg;
                work_next.bytes     = bytes_reg;
                work_next.avg_rate  = rd_row.avg_rate;
                work_next.inst_rate = rd_row.inst_rate;
                abs_el_next = $signed({1'b0, ts_reg}) - $signed({1'b0, begin_new});
                del_next    = $signed({1'b0, ts_reg}) - $signed({1'b0, rd_row.t_latest});
                dsz_next    = $signed({1'b0, bytes_reg}) - $signed({1'b0, rd_row.bytes});
            end
            S_AVG_WAIT:
            begin
                if (div_done)
                begin
                    work_next.avg_rate = div_quot;
                end
            end
            S_INST_WAIT:
            begin
                if (div_done)
                begin
                    work_next.inst_rate = div_quot;
                end
            end
            S_WRITE:
            begin
                if ((ob_reg == 32'd0) || (ob_reg < work_reg.t_begin))
                begin
                    ob_next = work_reg.t_begin;
                end
                if (ol_reg < work_reg.t_latest)
                begin
                    ol_next = work_reg.t_latest;
                end
            end
            S_SUM:
            begin
                // read one row a cycle, add it in the cycle after
                if (walk_issue)
                begin
                    walk_next = walk_reg + CNT_W'(1);
                    pend_next = 1'b1;
                end
                if (pend_reg)
                begin
                    acc_avg_next  = acc_avg_reg + 57'(rd_row.avg_rate);
                    acc_inst_next = acc_inst_reg + 57'(rd_row.inst_rate);
                    acc_b_next    = acc_b_reg + 56'(rd_row.bytes);
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    odata_next  = {3'b000, acc_b_reg, acc_inst_reg, acc_avg_reg,
                                   elapsed, status_reg};
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            active_reg <= '0;
            ob_reg     <= '0;
            ol_reg     <= '0;
            walk_reg   <= '0;
            pend_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            active_reg <= active_next;
            ob_reg     <= ob_next;
            ol_reg     <= ol_next;
            walk_reg   <= walk_next;
            pend_reg   <= pend_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        ts_reg       <= ts_next;
        bytes_reg    <= bytes_next;
        status_reg   <= status_next;
        work_reg     <= work_next;
        abs_el_reg   <= abs_el_next;
        del_reg      <= del_next;
        dsz_reg      <= dsz_next;
        acc_avg_reg  <= acc_avg_next;
        acc_inst_reg <= acc_inst_next;
        acc_b_reg    <= acc_b_next;
        odata_reg    <= odata_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;

    // the table walk never runs past the active count
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        walk_reg <= active_reg)
        else $error("table walk past active count");

    // divider results arrive only while the sequencer waits for them
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_AVG_WAIT || state_reg == S_INST_WAIT))
        else $error("divider done outside a wait state");

    // only accepted reports reach the table write
    a_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE) |-> (status_reg == STAT_OK))
        else $error("rejected report written to table");

    // a rejected count leaves the active count alone
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && count_bad) |=> $stable(active_reg))
        else $error("active count changed on rejected count");

endmodule

// ===== tb/srtm_checker.sv =====
// ---------------------------------------------------------------------------
// srtm_checker: result checker for the stripe transfer rate monitor
// Watches both stream channels, runs a behavioral copy of the stripe table
// on each accepted report and compares every result against it in order.
// ---------------------------------------------------------------------------
module srtm_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic [srtm_pkg::IN_W-1:0]  s_tdata,
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic [srtm_pkg::OUT_W-1:0] m_tdata,
    output int                         fail_count,
    output int                         pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import srtm_pkg::*;

    typedef struct packed {
        logic [55:0]        total_bytes;
        logic [56:0]        sum_inst;
        logic [56:0]        sum_avg;
        logic [32:0]        elapsed;
        status_t            status;
    } report_result_t;

    logic [31:0]        tbl_begin  [MAX_STRIPES];
    logic [31:0]        tbl_latest [MAX_STRIPES];
    logic [47:0]        tbl_bytes  [MAX_STRIPES];
    logic signed [63:0] tbl_avg    [MAX_STRIPES];
    logic signed [63:0] tbl_inst   [MAX_STRIPES];
    int                 active_cnt;
    logic [31:0]        all_begin;
    logic [31:0]        all_latest;
    report_result_t     expected_results[$];

    assign pending = expected_results.size();

    // Apply one report to the table copy and build its result
    function automatic report_result_t predict_report(logic [IN_W-1:0] req);
        int                 idx;
        int                 cnt;
        logic [31:0]        now;
        logic [47:0]        nbytes;
        logic signed [63:0] abs_el;
        logic signed [63:0] diff_el;
        logic signed [63:0] diff_sz;
        logic [63:0]        s_avg;
        logic [63:0]        s_inst;
        logic [63:0]        s_bytes;
        logic signed [63:0] el;
        report_result_t     r;
        idx    = $signed(req[15:0]);
        cnt    = req[31:16];
        now    = req[63:32];
        nbytes = req[111:64];
        r.status = STAT_OK;
        if (cnt > MAX_STRIPES)
        begin
            r.status = STAT_COUNT;
        end
        else
        begin
            for (int i = active_cnt; i < cnt; i++)
            begin
                tbl_begin[i]  = '0;
                tbl_latest[i] = '0;
                tbl_bytes[i]  = '0;
                tbl_avg[i]    = '0;
                tbl_inst[i]   = '0;
            end
            active_cnt = cnt;
            if (idx < 0 || idx >= active_cnt)
            begin
                r.status = STAT_INDEX;
            end
            else
            begin
                if (tbl_begin[idx] == 0)
                    tbl_begin[idx] = now;
                abs_el  = $signed({32'd0, now}) - $signed({32'd0, tbl_begin[idx]});
                diff_el = $signed({32'd0, now}) - $signed({32'd0, tbl_latest[idx]});
                diff_sz = $signed({16'd0, nbytes}) - $signed({16'd0, tbl_bytes[idx]});
                tbl_latest[idx] = now;
                tbl_bytes[idx]  = nbytes;
                if (abs_el != 0)
                    tbl_avg[idx] = $signed({16'd0, nbytes}) / abs_el;
                if (diff_el != 0)
                    tbl_inst[idx] = diff_sz / diff_el;
                if (all_begin == 0 || all_begin < tbl_begin[idx])
                    all_begin = tbl_begin[idx];
                if (all_latest < tbl_latest[idx])
                    all_latest = tbl_latest[idx];
            end
        end
        s_avg   = '0;
        s_inst  = '0;
        s_bytes = '0;
        for (int i = 0; i < active_cnt; i++)
        begin
            s_avg   += tbl_avg[i];
            s_inst  += tbl_inst[i];
            s_bytes += tbl_bytes[i];
        end
        el = $signed({32'd0, all_latest}) - $signed({32'd0, all_begin});
        r.elapsed     = el[32:0];
        r.sum_avg     = s_avg[56:0];
        r.sum_inst    = s_inst[56:0];
        r.total_bytes = s_bytes[55:0];
        return r;
    endfunction

    // Predict on each accepted request, compare on each accepted result
    always @(posedge clk or negedge rst_n)
    begin
        report_result_t want;
        report_result_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_STRIPES; i++)
            begin
                tbl_begin[i]  = '0;
                tbl_latest[i] = '0;
                tbl_bytes[i]  = '0;
                tbl_avg[i]    = '0;
                tbl_inst[i]   = '0;
            end
            active_cnt = 0;
            all_begin  = '0;
            all_latest = '0;
            expected_results.delete();
            fail_count = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_report(s_tdata));
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[204:0];
                if (m_tdata[207:205] != 3'd0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("pad bits exp 0 act %h", m_tdata[207:205]);
                end
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result %h", m_tdata);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.status != want.status || got.elapsed != want.elapsed ||
                        got.sum_avg != want.sum_avg || got.sum_inst != want.sum_inst ||
                        got.total_bytes != want.total_bytes)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch exp st=%0d el=%h avg=%h inst=%h by=%h / act st=%0d el=%h avg=%h inst=%h by=%h",
                                want.status, want.elapsed, want.sum_avg, want.sum_inst,
                                want.total_bytes, got.status, got.elapsed, got.sum_avg,
                                got.sum_inst, got.total_bytes);
                    end
                end
            end
        end
    end
endmodule

// ===== tb/tb.sv =====
// ---------------------------------------------------------------------------
// tb: stimulus top for the stripe transfer rate monitor
// Sends directed and random stripe progress reports with random idle gaps
// on both channels; the checker module predicts and compares results.
// ---------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import srtm_pkg::*;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;
    int                fail_count;
    int                pending;
    int                cycle_cnt;
    bit                calm;
    int                cur_count;
    logic [31:0]       clock_now;

    stripe_transfer_rate_monitor dut (.*);

    srtm_checker u_checker (.*);

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > 3000000)
        begin
            $display("[stripe_transfer_rate_monitor] ERROR");
            $finish;
        end
    end

    // Stall the result channel in bursts
    always @(negedge clk)
    begin
        int hold;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            m_tready <= 1'b0;
            hold = $urandom_range(1, 14);
            repeat (hold) @(negedge clk);
        end
        m_tready <= 1'b1;
    end

    // Present one request and hold it until accepted
    task automatic send_report(int idx, int cnt, logic [31:0] ts, logic [47:0] nb);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 14);
            repeat (gap) @(negedge clk);
        end
        s_tdata  <= {nb, ts, cnt[15:0], idx[15:0]};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        s_tvalid <= 1'b0;
        @(negedge clk);
    endtask

    // Mostly well-formed reports on a running clock, plus noise
    task automatic random_report();
        int sel;
        int idx;
        sel = $urandom_range(0, 99);
        if (sel < 5)
            cur_count = $urandom_range(1, 2) == 1 ? $urandom_range(1, 12) : $urandom_range(1, 256);
        clock_now += $urandom_range(0, 3);
        idx = $urandom_range(0, cur_count - 1);
        if (sel < 80)
            send_report(idx, cur_count, clock_now, 48'({$urandom, $urandom}));
        else if (sel < 88)
            send_report(idx, cur_count, $urandom, 48'({$urandom, $urandom}));
        else if (sel < 94)
            send_report($urandom, cur_count, clock_now, 48'($urandom));
        else
            send_report($urandom, $urandom, $urandom, 48'({$urandom, $urandom}));
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        calm     = 1'b0;
        cycle_cnt = 0;
        cur_count = 8;
        clock_now = 32'd1000;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: count too high, index out of range, extremes, first report
        send_report(0, 257, 5, 100);
        send_report(0, 65535, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send_report(-32768, 4, 10, 1);
        send_report(32767, 4, 10, 1);
        send_report(4, 4, 10, 1);
        send_report(0, 4, 0, 0);
        send_report(0, 4, 0, 500);
        send_report(0, 4, 10, 1000);
        send_report(0, 4, 10, 2000);
        send_report(0, 4, 20, 48'hFFFF_FFFF_FFFF);
        send_report(0, 4, 30, 5);
        send_report(1, 4, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send_report(1, 4, 1, 0);
        send_report(3, 2, 50, 7);
        send_report(1, 2, 60, 70);
        send_report(3, 4, 70, 9);
        send_report(255, 256, 100, 48'h8000_0000_0000);
        send_report(255, 256, 200, 0);
        send_report(0, 0, 5, 5);
        send_report(0, 256, 32'h8000_0000, 48'h7FFF_FFFF_FFFF);
        send_report(-1, 256, 1, 1);

        // Let the block drain completely once
        while (pending != 0)
            @(negedge clk);

        cur_count = 8;
        for (int n = 0; n < 1400; n++)
        begin
            if (n == 1200)
                calm = 1'b1;
            random_report();
        end

        while (pending != 0)
            @(negedge clk);
        repeat (400) @(negedge clk);
        if (fail_count == 0)
            $display("[stripe_transfer_rate_monitor] OK");
        else
            $display("[stripe_transfer_rate_monitor] ERROR");
        $finish;
    end
endmodule
